// ===== hw/rtl/qpat_pkg.sv =====
package qpat_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned GAIN_W  = 31;

    // register map, word index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_TARGET_POS_X = 3'd0,
        REG_TARGET_POS_Y = 3'd1,
        REG_TARGET_POS_Z = 3'd2,
        REG_TARGET_VEL_X = 3'd3,
        REG_TARGET_VEL_Y = 3'd4,
        REG_TARGET_VEL_Z = 3'd5,
        REG_GAIN_POS     = 3'd6,
        REG_GAIN_VEL     = 3'd7
    } reg_idx_t;

    // gravity 9.8 and mass 2.856, Q16.16
    localparam logic [19:0] G_Q16    = 20'd642253;
    localparam logic [17:0] MASS_Q16 = 18'd187171;

    localparam logic signed [31:0] RST_TARGET_POS_Z = -32'sd196608;
    localparam logic [GAIN_W-1:0]  RST_GAIN_POS     = 31'd207238;
    localparam logic [GAIN_W-1:0]  RST_GAIN_VEL     = 31'd177360;

    typedef struct packed {
        logic signed [31:0] meas_pos_x;
        logic signed [31:0] meas_pos_y;
        logic signed [31:0] meas_pos_z;
        logic signed [31:0] meas_vel_x;
        logic signed [31:0] meas_vel_y;
        logic signed [31:0] meas_vel_z;
        logic signed [31:0] att_w;
        logic signed [31:0] att_x;
        logic signed [31:0] att_y;
        logic signed [31:0] att_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] cmd_att_w;
        logic signed [31:0] cmd_att_x;
        logic signed [31:0] cmd_att_y;
        logic signed [31:0] cmd_att_z;
        logic [31:0]        cmd_thrust;
        logic               degenerate;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] target_pos_x;
        logic signed [31:0] target_pos_y;
        logic signed [31:0] target_pos_z;
        logic signed [31:0] target_vel_x;
        logic signed [31:0] target_vel_y;
        logic signed [31:0] target_vel_z;
        logic [GAIN_W-1:0]  gain_position;
        logic [GAIN_W-1:0]  gain_velocity;
    } cfg_t;

endpackage

// ===== hw/rtl/qpat_meas_if.sv =====
interface qpat_meas_if;
    logic               valid;
    logic               ready;
    qpat_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/qpat_cmd_if.sv =====
interface qpat_cmd_if;
    logic                valid;
    logic                ready;
    qpat_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/qpat_core.sv =====
module qpat_core (
    input  logic            clk,
    input  logic            rst_n,
    input  qpat_pkg::cfg_t  cfg,
    qpat_meas_if.sink       meas,
    qpat_cmd_if.source      cmd
);

    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int FRONT_STAGES = 7;
    localparam int MID_STAGES   = 7;
    localparam int SHIFT_MAX    = 21;
    localparam int IDX_D0       = FRONT_STAGES + SQRT_STEPS + MID_STAGES + SQRT_STEPS;
    localparam int DEPTH        = IDX_D0 + 1 + DIV_STEPS + 1;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } root_t;

    typedef struct packed {
        logic             big;
        logic [8:0][33:0] p;
    } side1_t;

    typedef struct packed {
        logic             degen;
        logic [31:0]      thrust;
        logic [3:0]       sgn;
        logic [3:0][30:0] nm;
    } side2_t;

    typedef struct packed {
        logic        degen;
        logic [31:0] thrust;
        logic [3:0]  sgn;
        logic [31:0] d;
    } side3_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] quo;
        logic [30:0] low;
    } div_t;

    function automatic root_t root_step(root_t a, logic [63:0] b);
        root_t       o;
        logic [63:0] tr;
        tr = a.r + b;
        if (a.v >= tr)
        begin
            o.v = a.v - tr;
            o.r = (a.r >> 1) + b;
        end
        else
        begin
            o.v = a.v;
            o.r = a.r >> 1;
        end
        return o;
    endfunction

    function automatic div_t div_step(div_t a, logic [31:0] d);
        div_t        o;
        logic [32:0] tr;
        tr = {a.rem, a.low[30]};
        o.low = {a.low[29:0], 1'b0};
        if (tr >= {1'b0, d})
        begin
            tr    = tr - {1'b0, d};
            o.quo = {a.quo[29:0], 1'b1};
        end
        else
        begin
            o.quo = {a.quo[29:0], 1'b0};
        end
        o.rem = tr[31:0];
        return o;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic fits31(logic signed [51:0] v);
        return (v <= 52'sd2147483647) && (v >= -52'sd2147483647);
    endfunction

    function automatic logic [30:0] mag31(logic signed [31:0] v);
        logic [31:0] a;
        a = v[31] ? 32'(-v) : 32'(v);
        return a[30:0];
    endfunction

    // ---------------- pipeline control ----------------
    logic             en;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    assign en         = !vld_reg[DEPTH-1] || cmd.ready;
    assign meas.ready = en;
    assign vld_next   = {vld_reg[DEPTH-2:0], meas.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // ---------------- S1: errors ----------------
    logic signed [32:0] ep1_reg [3];
    logic signed [32:0] ev1_reg [3];
    logic signed [31:0] qw1_reg, qx1_reg, qy1_reg, qz1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ep1_reg[0] <= 33'(meas.data.meas_pos_x) - 33'(cfg.target_pos_x);
            ep1_reg[1] <= 33'(meas.data.meas_pos_y) - 33'(cfg.target_pos_y);
            ep1_reg[2] <= 33'(meas.data.meas_pos_z) - 33'(cfg.target_pos_z);
            ev1_reg[0] <= 33'(meas.data.meas_vel_x) - 33'(cfg.target_vel_x);
            ev1_reg[1] <= 33'(meas.data.meas_vel_y) - 33'(cfg.target_vel_y);
            ev1_reg[2] <= 33'(meas.data.meas_vel_z) - 33'(cfg.target_vel_z);
            qw1_reg    <= meas.data.att_w;
            qx1_reg    <= meas.data.att_x;
            qy1_reg    <= meas.data.att_y;
            qz1_reg    <= meas.data.att_z;
        end
    end

    // ---------------- S2: products ----------------
    logic signed [31:0] kp_s, kv_s;
    logic signed [63:0] pxz2_reg, pwy2_reg, pyz2_reg, pwx2_reg, pxx2_reg, pyy2_reg;
    logic signed [63:0] gp2_reg [3];
    logic signed [63:0] gv2_reg [3];

    assign kp_s = $signed({1'b0, cfg.gain_position});
    assign kv_s = $signed({1'b0, cfg.gain_velocity});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxz2_reg <= 64'(qx1_reg * qz1_reg);
            pwy2_reg <= 64'(qw1_reg * qy1_reg);
            pyz2_reg <= 64'(qy1_reg * qz1_reg);
            pwx2_reg <= 64'(qw1_reg * qx1_reg);
            pxx2_reg <= 64'(qx1_reg * qx1_reg);
            pyy2_reg <= 64'(qy1_reg * qy1_reg);
            for (int i = 0; i < 3; i++)
            begin
                gp2_reg[i] <= 64'(ep1_reg[i] * kp_s);
                gv2_reg[i] <= 64'(ev1_reg[i] * kv_s);
            end
        end
    end

    // ---------------- S3: thrust direction and control vector ----------------
    logic signed [63:0] t_full [3];
    logic signed [63:0] u_full [3];
    logic signed [31:0] t3_reg [3];
    logic signed [51:0] u3_reg [3];

    always_comb
    begin
        t_full[0] = -((pxz2_reg >>> 29) + (pwy2_reg >>> 29));
        t_full[1] = -((pyz2_reg >>> 29) - (pwx2_reg >>> 29));
        t_full[2] = (pxx2_reg >>> 29) + (pyy2_reg >>> 29) - 64'sd1073741824;
        for (int i = 0; i < 3; i++)
            u_full[i] = -((gp2_reg[i] >>> 16) + (gv2_reg[i] >>> 16));
        u_full[2] = u_full[2] - $signed({44'd0, qpat_pkg::G_Q16});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t3_reg[i] <= sat32(t_full[i]);
                u3_reg[i] <= u_full[i][51:0];
            end
        end
    end

    // ---------------- S4: common scale search ----------------
    logic [4:0]         s_next;
    logic [4:0]         s4_reg;
    logic signed [31:0] t4_reg [3];
    logic signed [51:0] u4_reg [3];

    always_comb
    begin
        s_next = 5'(SHIFT_MAX);
        for (int k = SHIFT_MAX; k >= 0; k--)
            if (fits31(u3_reg[0] >>> k) && fits31(u3_reg[1] >>> k) && fits31(u3_reg[2] >>> k))
                s_next = 5'(k);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg <= s_next;
            t4_reg <= t3_reg;
            u4_reg <= u3_reg;
        end
    end

    // ---------------- S5: apply scale ----------------
    logic signed [51:0] u_sh [3];
    logic signed [31:0] us5_reg [3];
    logic signed [31:0] t5_reg [3];
    logic               big5_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            u_sh[i] = u4_reg[i] >>> s4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                us5_reg[i] <= u_sh[i][31:0];
            t5_reg   <= t4_reg;
            big5_reg <= (s4_reg != 5'd0);
        end
    end

    // ---------------- S6: squares and t*u products ----------------
    logic [30:0]        um6 [3];
    logic [61:0]        sq6_reg [3];
    logic signed [63:0] tp6_reg [3][3];
    logic               big6_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            um6[i] = mag31(us5_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq6_reg[i] <= 62'(um6[i] * um6[i]);
                for (int j = 0; j < 3; j++)
                    tp6_reg[i][j] <= 64'(t5_reg[i] * us5_reg[j]);
            end
            big6_reg <= big5_reg;
        end
    end

    // ---------------- S7: sum of squares ----------------
    root_t  root7_reg;
    side1_t side7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root7_reg.v   <= 64'(sq6_reg[0]) + 64'(sq6_reg[1]) + 64'(sq6_reg[2]);
            root7_reg.r   <= '0;
            side7_reg.big <= big6_reg;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    side7_reg.p[i*3+j] <= tp6_reg[i][j][63:30];
        end
    end

    // ---------------- |u| root, one result bit per stage ----------------
    root_t  r1_reg [SQRT_STEPS];
    side1_t s1_reg [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_root1
        localparam logic [63:0] BIT_J = 64'd1 << (62 - 2*j);
        if (j == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r1_reg[j] <= root_step(root7_reg, BIT_J);
                    s1_reg[j] <= side7_reg;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r1_reg[j] <= root_step(r1_reg[j-1], BIT_J);
                    s1_reg[j] <= s1_reg[j-1];
                end
            end
        end
    end

    // ---------------- T1: thrust product, raw quaternion ----------------
    logic [31:0]        n1;
    side1_t             sd1;
    logic signed [37:0] pe [9];
    logic signed [37:0] qc [4];
    logic [49:0]        tm_t1_reg;
    logic               big_t1_reg;
    logic signed [37:0] q_t1_reg [4];

    assign n1  = r1_reg[SQRT_STEPS-1].r[31:0];
    assign sd1 = s1_reg[SQRT_STEPS-1];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
            pe[k] = 38'($signed(sd1.p[k]));
        qc[0] = pe[0] + pe[4] + pe[8] + $signed({6'd0, n1});
        qc[1] = pe[5] - pe[7];
        qc[2] = pe[6] - pe[2];
        qc[3] = pe[1] - pe[3];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tm_t1_reg  <= 50'(n1 * qpat_pkg::MASS_Q16);
            big_t1_reg <= sd1.big;
            q_t1_reg   <= qc;
        end
    end

    // ---------------- T2: thrust rounding, magnitudes ----------------
    logic [50:0]  rnd;
    logic [34:0]  th;
    logic [31:0]  th_sat;
    logic [31:0]  thrust_t2_reg;
    logic [36:0]  m_t2_reg [4];
    logic [3:0]   sgn_t2_reg;

    always_comb
    begin
        rnd    = 51'(tm_t1_reg) + 51'd32768;
        th     = rnd[50:16];
        th_sat = (th > 35'h0FFFFFFFF) ? 32'hFFFFFFFF : th[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            thrust_t2_reg <= big_t1_reg ? 32'hFFFFFFFF : th_sat;
            for (int i = 0; i < 4; i++)
            begin
                m_t2_reg[i]   <= q_t1_reg[i][37] ? 37'(-q_t1_reg[i]) : 37'(q_t1_reg[i]);
                sgn_t2_reg[i] <= q_t1_reg[i][37];
            end
        end
    end

    // ---------------- T3: largest magnitude ----------------
    logic [36:0] mx_a, mx_b;
    logic [36:0] maxm_t3_reg;
    logic [36:0] m_t3_reg [4];
    logic [3:0]  sgn_t3_reg;
    logic [31:0] thrust_t3_reg;

    assign mx_a = (m_t2_reg[0] > m_t2_reg[1]) ? m_t2_reg[0] : m_t2_reg[1];
    assign mx_b = (m_t2_reg[2] > m_t2_reg[3]) ? m_t2_reg[2] : m_t2_reg[3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            maxm_t3_reg   <= (mx_a > mx_b) ? mx_a : mx_b;
            m_t3_reg      <= m_t2_reg;
            sgn_t3_reg    <= sgn_t2_reg;
            thrust_t3_reg <= thrust_t2_reg;
        end
    end

    // ---------------- T4: leading one ----------------
    logic [5:0]  pos_c;
    logic [5:0]  pos_t4_reg;
    logic        degen_t4_reg;
    logic [36:0] m_t4_reg [4];
    logic [3:0]  sgn_t4_reg;
    logic [31:0] thrust_t4_reg;

    always_comb
    begin
        pos_c = 6'd0;
        for (int k = 0; k < 37; k++)
            if (maxm_t3_reg[k])
                pos_c = 6'(k);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_t4_reg    <= pos_c;
            degen_t4_reg  <= (maxm_t3_reg == 37'd0);
            m_t4_reg      <= m_t3_reg;
            sgn_t4_reg    <= sgn_t3_reg;
            thrust_t4_reg <= thrust_t3_reg;
        end
    end

    // ---------------- T5: normalize so the largest sits in [2^30, 2^31) ----------------
    logic [36:0] nsh [4];
    logic [30:0] nm_t5_reg [4];
    logic        degen_t5_reg;
    logic [3:0]  sgn_t5_reg;
    logic [31:0] thrust_t5_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            nsh[i] = (pos_t4_reg > 6'd30) ? (m_t4_reg[i] >> (pos_t4_reg - 6'd30))
                                          : (m_t4_reg[i] << (6'd30 - pos_t4_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                nm_t5_reg[i] <= nsh[i][30:0];
            degen_t5_reg  <= degen_t4_reg;
            sgn_t5_reg    <= sgn_t4_reg;
            thrust_t5_reg <= thrust_t4_reg;
        end
    end

    // ---------------- T6: squares ----------------
    logic [61:0] sq_t6_reg [4];
    logic [30:0] nm_t6_reg [4];
    logic        degen_t6_reg;
    logic [3:0]  sgn_t6_reg;
    logic [31:0] thrust_t6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                sq_t6_reg[i] <= 62'(nm_t5_reg[i] * nm_t5_reg[i]);
            nm_t6_reg     <= nm_t5_reg;
            degen_t6_reg  <= degen_t5_reg;
            sgn_t6_reg    <= sgn_t5_reg;
            thrust_t6_reg <= thrust_t5_reg;
        end
    end

    // ---------------- T7: sum of squares ----------------
    root_t  root_t7_reg;
    side2_t side_t7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_t7_reg.v <= 64'(sq_t6_reg[0]) + 64'(sq_t6_reg[1])
                           + 64'(sq_t6_reg[2]) + 64'(sq_t6_reg[3]);
            root_t7_reg.r <= '0;
            side_t7_reg.degen  <= degen_t6_reg;
            side_t7_reg.thrust <= thrust_t6_reg;
            side_t7_reg.sgn    <= sgn_t6_reg;
            for (int i = 0; i < 4; i++)
                side_t7_reg.nm[i] <= nm_t6_reg[i];
        end
    end

    // ---------------- quaternion norm root ----------------
    root_t  r2_reg [SQRT_STEPS];
    side2_t s2_reg [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_root2
        localparam logic [63:0] BIT_J = 64'd1 << (62 - 2*j);
        if (j == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r2_reg[j] <= root_step(root_t7_reg, BIT_J);
                    s2_reg[j] <= side_t7_reg;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r2_reg[j] <= root_step(r2_reg[j-1], BIT_J);
                    s2_reg[j] <= s2_reg[j-1];
                end
            end
        end
    end

    // ---------------- D0: rounded numerators ----------------
    logic [31:0]         n2;
    side2_t              sd2;
    logic [61:0]         num [4];
    div_t   [3:0]        dv0_reg;
    side3_t              sd0_reg;

    assign n2  = r2_reg[SQRT_STEPS-1].r[31:0];
    assign sd2 = s2_reg[SQRT_STEPS-1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            num[i] = {1'b0, sd2.nm[i], 30'd0} + 62'(n2 >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                dv0_reg[i].rem <= {1'b0, num[i][61:31]};
                dv0_reg[i].quo <= '0;
                dv0_reg[i].low <= num[i][30:0];
            end
            sd0_reg.degen  <= sd2.degen;
            sd0_reg.thrust <= sd2.thrust;
            sd0_reg.sgn    <= sd2.sgn;
            sd0_reg.d      <= n2;
        end
    end

    // ---------------- restoring divide, four lanes, one quotient bit per stage ----------------
    div_t   [3:0] dv_reg [DIV_STEPS];
    side3_t       sd_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        if (j == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int i = 0; i < 4; i++)
                        dv_reg[j][i] <= div_step(dv0_reg[i], sd0_reg.d);
                    sd_reg[j] <= sd0_reg;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int i = 0; i < 4; i++)
                        dv_reg[j][i] <= div_step(dv_reg[j-1][i], sd_reg[j-1].d);
                    sd_reg[j] <= sd_reg[j-1];
                end
            end
        end
    end

    // ---------------- output register ----------------
    side3_t              sdl;
    logic [31:0]         qa [4];
    qpat_pkg::out_word_t out_reg;

    assign sdl = sd_reg[DIV_STEPS-1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            qa[i] = {1'b0, dv_reg[DIV_STEPS-1][i].quo};
            if (sdl.degen)
                qa[i] = 32'd0;
            else if (sdl.sgn[i])
                qa[i] = 32'(-qa[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.cmd_att_w  <= $signed(qa[0]);
            out_reg.cmd_att_x  <= $signed(qa[1]);
            out_reg.cmd_att_y  <= $signed(qa[2]);
            out_reg.cmd_att_z  <= $signed(qa[3]);
            out_reg.cmd_thrust <= sdl.thrust;
            out_reg.degenerate <= sdl.degen;
        end
    end

    assign cmd.valid = vld_reg[DEPTH-1];
    assign cmd.data  = out_reg;

    // ---------------- assertions ----------------
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DEPTH-1] && !cmd.ready) |-> !meas.ready)
        else $error("input taken while output word blocked");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.data.degenerate) |->
        (cmd.data.cmd_att_w == 32'sd0 && cmd.data.cmd_att_x == 32'sd0 &&
         cmd.data.cmd_att_y == 32'sd0 && cmd.data.cmd_att_z == 32'sd0))
        else $error("degenerate word carries nonzero quaternion");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[IDX_D0] && !sd0_reg.degen) |-> sd0_reg.d[31:30] != 2'b00)
        else $error("normalized quaternion norm below 2^30");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DEPTH-2] && !sdl.degen) |->
        (dv_reg[DIV_STEPS-1][0].rem < sdl.d && dv_reg[DIV_STEPS-1][3].rem < sdl.d))
        else $error("divider remainder not below divisor");

endmodule

// ===== hw/rtl/quadrotor_position_to_attitude_thrust.sv =====
// Quadrotor position controller. Each input word carries a measured NED position, velocity
// and attitude quaternion (Q16.16 / Q2.30); each yields exactly one output word holding the
// desired attitude quaternion (Q2.30, normalized shortest arc from the current thrust axis
// to the control vector), the collective thrust |u|*mass (unsigned Q16.16, saturating) and a
// degenerate flag that marks a zero quaternion. The datapath is a 111-stage pipeline that
// takes one word per clock whenever no output stall holds it; its depth is set by
// two 32-stage square roots (control vector norm and quaternion norm, one root bit per
// stage) and a 31-stage restoring divider (four lanes, one quotient bit per stage), plus
// front, middle and output stages. A stall on the output freezes the whole pipe; nothing is
// dropped or repeated. Setpoints and gains are written over the APB port, register i at
// byte address 4*i, and must only change while the pipe is empty. Gravity 9.8 m/s^2 and mass
// 2.856 kg are fixed.
module quadrotor_position_to_attitude_thrust (
    input  logic                           clk,
    input  logic                           rst_n,
    qpat_meas_if.sink                      meas,
    qpat_cmd_if.source                     cmd,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qpat_pkg::ADDR_W-1:0]    paddr,
    input  logic [qpat_pkg::DATA_W-1:0]    pwdata,
    output logic [qpat_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    // setpoint and gain registers
    logic signed [31:0]             tpx_reg, tpy_reg, tpz_reg;
    logic signed [31:0]             tvx_reg, tvy_reg, tvz_reg;
    logic [qpat_pkg::GAIN_W-1:0]    kp_reg, kv_reg;
    qpat_pkg::reg_idx_t             idx;
    logic                           wr;
    qpat_pkg::cfg_t                 cfg;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = qpat_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpx_reg <= '0;
            tpy_reg <= '0;
            tpz_reg <= qpat_pkg::RST_TARGET_POS_Z;
            tvx_reg <= '0;
            tvy_reg <= '0;
            tvz_reg <= '0;
            kp_reg  <= qpat_pkg::RST_GAIN_POS;
            kv_reg  <= qpat_pkg::RST_GAIN_VEL;
        end
        else if (wr)
        begin
            case (idx)
                qpat_pkg::REG_TARGET_POS_X: tpx_reg <= $signed(pwdata);
                qpat_pkg::REG_TARGET_POS_Y: tpy_reg <= $signed(pwdata);
                qpat_pkg::REG_TARGET_POS_Z: tpz_reg <= $signed(pwdata);
                qpat_pkg::REG_TARGET_VEL_X: tvx_reg <= $signed(pwdata);
                qpat_pkg::REG_TARGET_VEL_Y: tvy_reg <= $signed(pwdata);
                qpat_pkg::REG_TARGET_VEL_Z: tvz_reg <= $signed(pwdata);
                qpat_pkg::REG_GAIN_POS:     kp_reg  <= pwdata[30:0];
                qpat_pkg::REG_GAIN_VEL:     kv_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // read mux; gains read back zero in bit 31
    always_comb
    begin
        case (idx)
            qpat_pkg::REG_TARGET_POS_X: prdata = tpx_reg;
            qpat_pkg::REG_TARGET_POS_Y: prdata = tpy_reg;
            qpat_pkg::REG_TARGET_POS_Z: prdata = tpz_reg;
            qpat_pkg::REG_TARGET_VEL_X: prdata = tvx_reg;
            qpat_pkg::REG_TARGET_VEL_Y: prdata = tvy_reg;
            qpat_pkg::REG_TARGET_VEL_Z: prdata = tvz_reg;
            qpat_pkg::REG_GAIN_POS:     prdata = {1'b0, kp_reg};
            qpat_pkg::REG_GAIN_VEL:     prdata = {1'b0, kv_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.target_pos_x  = tpx_reg;
    assign cfg.target_pos_y  = tpy_reg;
    assign cfg.target_pos_z  = tpz_reg;
    assign cfg.target_vel_x  = tvx_reg;
    assign cfg.target_vel_y  = tvy_reg;
    assign cfg.target_vel_z  = tvz_reg;
    assign cfg.gain_position = kp_reg;
    assign cfg.gain_velocity = kv_reg;

    // datapath: errors, gains, thrust axis, norm roots, normalization divide
    qpat_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .meas  (meas),
        .cmd   (cmd)
    );

endmodule

// ===== sim/qpat_checker.sv =====
`timescale 1ns / 100ps

module qpat_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                meas_valid,
    input  logic                meas_ready,
    input  qpat_pkg::in_word_t  meas_data,
    input  logic                cmd_valid,
    input  logic                cmd_ready,
    input  qpat_pkg::out_word_t cmd_data,
    input  qpat_pkg::cfg_t      cfg,
    output int                  n_fail,
    output int                  n_pending
);

    localparam longint GRAV = 642253;
    localparam longint MASS = 187171;

    qpat_pkg::out_word_t cmd_expected[$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic qpat_pkg::out_word_t predict_attitude_cmd(qpat_pkg::in_word_t d,
                                                                 qpat_pkg::cfg_t c);
        qpat_pkg::out_word_t o;
        longint w, x, y, z, kp, kv, ep, ev;
        longint thr_dir[3];
        longint ctl[3];
        longint q[4];
        longint unsigned m[4];
        longint unsigned acc, nrm, mx, thr, r;
        int sc;
        bit big;
        w = d.att_w;
        x = d.att_x;
        y = d.att_y;
        z = d.att_z;
        kp = longint'(c.gain_position);
        kv = longint'(c.gain_velocity);
        thr_dir[0] = -(floor_shr(x * z, 29) + floor_shr(w * y, 29));
        thr_dir[1] = -(floor_shr(y * z, 29) - floor_shr(w * x, 29));
        thr_dir[2] = floor_shr(x * x, 29) + floor_shr(y * y, 29) - (64'sd1 << 30);
        ep = longint'(d.meas_pos_x) - longint'(c.target_pos_x);
        ev = longint'(d.meas_vel_x) - longint'(c.target_vel_x);
        ctl[0] = -(floor_shr(ep * kp, 16) + floor_shr(ev * kv, 16));
        ep = longint'(d.meas_pos_y) - longint'(c.target_pos_y);
        ev = longint'(d.meas_vel_y) - longint'(c.target_vel_y);
        ctl[1] = -(floor_shr(ep * kp, 16) + floor_shr(ev * kv, 16));
        ep = longint'(d.meas_pos_z) - longint'(c.target_pos_z);
        ev = longint'(d.meas_vel_z) - longint'(c.target_vel_z);
        ctl[2] = -(floor_shr(ep * kp, 16) + floor_shr(ev * kv, 16)) - GRAV;
        for (int i = 0; i < 3; i++)
            thr_dir[i] = clamp32(thr_dir[i]);
        sc = 0;
        forever
        begin
            big = 0;
            for (int i = 0; i < 3; i++)
                if (abs64(ctl[i]) >= (64'sd1 << 31))
                    big = 1;
            if (!big)
                break;
            for (int i = 0; i < 3; i++)
                ctl[i] = floor_shr(ctl[i], 1);
            sc++;
        end
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += abs64(ctl[i]) * abs64(ctl[i]);
        nrm = int_sqrt(acc);
        if (sc > 0)
            thr = 64'hFFFF_FFFF;
        else
        begin
            thr = (nrm * MASS + 32768) >> 16;
            if (thr > 64'hFFFF_FFFF)
                thr = 64'hFFFF_FFFF;
        end
        q[0] = floor_shr(thr_dir[0] * ctl[0], 30) + floor_shr(thr_dir[1] * ctl[1], 30)
             + floor_shr(thr_dir[2] * ctl[2], 30) + longint'(nrm);
        q[1] = floor_shr(thr_dir[1] * ctl[2], 30) - floor_shr(thr_dir[2] * ctl[1], 30);
        q[2] = floor_shr(thr_dir[2] * ctl[0], 30) - floor_shr(thr_dir[0] * ctl[2], 30);
        q[3] = floor_shr(thr_dir[0] * ctl[1], 30) - floor_shr(thr_dir[1] * ctl[0], 30);
        mx = 0;
        for (int i = 0; i < 4; i++)
        begin
            m[i] = abs64(q[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        o = '0;
        if (mx == 0)
            o.degenerate = 1'b1;
        else
        begin
            while (mx >= (64'd1 << 31))
            begin
                for (int i = 0; i < 4; i++)
                    m[i] >>= 1;
                mx >>= 1;
            end
            while (mx < (64'd1 << 30))
            begin
                for (int i = 0; i < 4; i++)
                    m[i] <<= 1;
                mx <<= 1;
            end
            acc = 0;
            for (int i = 0; i < 4; i++)
                acc += m[i] * m[i];
            nrm = int_sqrt(acc);
            for (int i = 0; i < 4; i++)
            begin
                r = ((m[i] << 30) + nrm / 2) / nrm;
                q[i] = (q[i] < 0) ? -longint'(r) : longint'(r);
            end
            o.cmd_att_w = q[0][31:0];
            o.cmd_att_x = q[1][31:0];
            o.cmd_att_y = q[2][31:0];
            o.cmd_att_z = q[3][31:0];
        end
        o.cmd_thrust = thr[31:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        n_fail++;
    endtask

    initial
    begin
        n_fail    = 0;
        n_pending = 0;
    end

    always @(posedge clk)
    begin
        qpat_pkg::out_word_t e;
        if (rst_n)
        begin
            if (meas_valid && meas_ready)
                cmd_expected.push_back(predict_attitude_cmd(meas_data, cfg));
            if (cmd_valid && cmd_ready)
            begin
                if (cmd_expected.size() == 0)
                    report_mismatch("unexpected word", 0, 0);
                else
                begin
                    e = cmd_expected.pop_front();
                    if (cmd_data.cmd_att_w !== e.cmd_att_w)
                        report_mismatch("cmd_att_w", cmd_data.cmd_att_w, e.cmd_att_w);
                    if (cmd_data.cmd_att_x !== e.cmd_att_x)
                        report_mismatch("cmd_att_x", cmd_data.cmd_att_x, e.cmd_att_x);
                    if (cmd_data.cmd_att_y !== e.cmd_att_y)
                        report_mismatch("cmd_att_y", cmd_data.cmd_att_y, e.cmd_att_y);
                    if (cmd_data.cmd_att_z !== e.cmd_att_z)
                        report_mismatch("cmd_att_z", cmd_data.cmd_att_z, e.cmd_att_z);
                    if (cmd_data.cmd_thrust !== e.cmd_thrust)
                        report_mismatch("cmd_thrust", cmd_data.cmd_thrust, e.cmd_thrust);
                    if (cmd_data.degenerate !== e.degenerate)
                        report_mismatch("degenerate", cmd_data.degenerate, e.degenerate);
                end
            end
            n_pending = cmd_expected.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_LIMIT = 20000;   // idle cycles with no word moving
    localparam int DRAIN_CYCLES   = 250;     // > depth of the 111-stage pipe
    localparam longint Q30        = 64'sd1073741824;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [qpat_pkg::ADDR_W-1:0] paddr;
    logic [qpat_pkg::DATA_W-1:0] pwdata;
    logic [qpat_pkg::DATA_W-1:0] prdata;
    logic pready;

    qpat_meas_if meas ();
    qpat_cmd_if  cmd ();

    // shadow of the register file, handed to the checker's predictor
    qpat_pkg::cfg_t cfg;
    int   n_fail;
    int   n_pending;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   idle_cycles;

    quadrotor_position_to_attitude_thrust u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .meas    (meas.sink),
        .cmd     (cmd.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    qpat_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas.valid),
        .meas_ready (meas.ready),
        .meas_data  (meas.data),
        .cmd_valid  (cmd.valid),
        .cmd_ready  (cmd.ready),
        .cmd_data   (cmd.data),
        .cfg        (cfg),
        .n_fail     (n_fail),
        .n_pending  (n_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: random stalls at the falling edge
    always @(negedge clk)
        cmd.ready <= ($urandom_range(99) >= snk_idle_pct);

    // watchdog: counts cycles where nothing moves on either channel and psel is low
    always @(posedge clk)
    begin
        if ((meas.valid && meas.ready) || (cmd.valid && cmd.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("quadrotor_position_to_attitude_thrust test failed");
            $finish;
        end
    end

    // APB write: setup then access; pready is always high
    task automatic write_reg(qpat_pkg::reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            qpat_pkg::REG_TARGET_POS_X: cfg.target_pos_x  = val;
            qpat_pkg::REG_TARGET_POS_Y: cfg.target_pos_y  = val;
            qpat_pkg::REG_TARGET_POS_Z: cfg.target_pos_z  = val;
            qpat_pkg::REG_TARGET_VEL_X: cfg.target_vel_x  = val;
            qpat_pkg::REG_TARGET_VEL_Y: cfg.target_vel_y  = val;
            qpat_pkg::REG_TARGET_VEL_Z: cfg.target_vel_z  = val;
            qpat_pkg::REG_GAIN_POS:     cfg.gain_position = val[qpat_pkg::GAIN_W-1:0];
            default:                    cfg.gain_velocity = val[qpat_pkg::GAIN_W-1:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // called at a falling edge; holds the word until it is taken, valid stays
    // up afterwards so the next word can follow with no gap
    task automatic send_word(qpat_pkg::in_word_t d);
        while ($urandom_range(99) < src_idle_pct)
        begin
            meas.valid <= 1'b0;
            @(negedge clk);
        end
        meas.valid <= 1'b1;
        meas.data  <= d;
        @(posedge clk);
        while (!meas.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // wait until the pipe is empty before touching registers
    task automatic drain_pipe();
        meas.valid <= 1'b0;
        while (n_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(131072)) - 65536) <<< $urandom_range(6);
            default: return $urandom;
        endcase
    endfunction

    // mostly near-unit attitudes built from a random direction, some with raw components in [-Q30, Q30]
    function automatic qpat_pkg::in_word_t rand_word_item();
        qpat_pkg::in_word_t d;
        longint a, b, c, e, nsq;
        d.meas_pos_x = rand_word();
        d.meas_pos_y = rand_word();
        d.meas_pos_z = rand_word();
        d.meas_vel_x = rand_word();
        d.meas_vel_y = rand_word();
        d.meas_vel_z = rand_word();
        if ($urandom_range(4) == 0)
        begin
            d.att_w = $signed($urandom_range(2 * Q30)) - Q30;
            d.att_x = $signed($urandom_range(2 * Q30)) - Q30;
            d.att_y = $signed($urandom_range(2 * Q30)) - Q30;
            d.att_z = $signed($urandom_range(2 * Q30)) - Q30;
        end
        else
        begin
            a = $signed($urandom_range(65536)) - 32768;
            b = $signed($urandom_range(65536)) - 32768;
            c = $signed($urandom_range(65536)) - 32768;
            e = $signed($urandom_range(65536)) - 32768;
            nsq = a * a + b * b + c * c + e * e + 1;
            // scale to roughly unit length in Q2.30
            d.att_x = (b * Q30) / (longint'($sqrt(real'(nsq))) + 1);
            d.att_y = (c * Q30) / (longint'($sqrt(real'(nsq))) + 1);
            d.att_z = (e * Q30) / (longint'($sqrt(real'(nsq))) + 1);
            d.att_w = (a * Q30) / (longint'($sqrt(real'(nsq))) + 1);
        end
        return d;
    endfunction

    function automatic qpat_pkg::in_word_t make_item(logic [31:0] p, logic [31:0] v,
                                                     longint w, longint x,
                                                     longint y, longint z);
        qpat_pkg::in_word_t d;
        d.meas_pos_x = p;
        d.meas_pos_y = p;
        d.meas_pos_z = p;
        d.meas_vel_x = v;
        d.meas_vel_y = v;
        d.meas_vel_z = v;
        d.att_w = w;
        d.att_x = x;
        d.att_y = y;
        d.att_z = z;
        return d;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_word(rand_word_item());
    endtask

    initial
    begin
        qpat_pkg::in_word_t d;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        meas.valid  = 1'b0;
        meas.data   = '0;
        cmd.ready   = 1'b0;
        idle_cycles = 0;
        src_idle_pct = 14;
        snk_idle_pct = 79;
        cfg = '{target_pos_x: '0, target_pos_y: '0,
                target_pos_z: qpat_pkg::RST_TARGET_POS_Z,
                target_vel_x: '0, target_vel_y: '0, target_vel_z: '0,
                gain_position: qpat_pkg::RST_GAIN_POS,
                gain_velocity: qpat_pkg::RST_GAIN_VEL};
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset registers: hover, level and upside-down attitude
        send_word(make_item('0, '0, Q30, 0, 0, 0));
        // hover at setpoint: u = (0,0,-G) -> identity-like command
        d = make_item('0, '0, Q30, 0, 0, 0);
        d.meas_pos_z = qpat_pkg::RST_TARGET_POS_Z;
        send_word(d);
        // upside down: t parallel-opposite u gives the zero quaternion
        d.att_w = 0;
        d.att_x = Q30;
        send_word(d);
        // zero attitude (non-unit), and out-of-range attitude extremes
        send_word(make_item('0, '0, 0, 0, 0, 0));
        send_word(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, Q30, Q30, Q30, Q30));
        send_word(make_item(32'h8000_0000, 32'h8000_0000, -Q30, -Q30, -Q30, -Q30));
        send_word(make_item(32'h8000_0000, 32'h7FFF_FFFF, -Q30, Q30, -Q30, Q30));
        send_word(make_item(32'hFFFF_FFFF, 32'h0000_0001, Q30, -Q30, Q30, -Q30));
        send_word(make_item(32'h0001_0000, 32'hFFFF_0000, 0, 0, Q30, 0));
        send_word(make_item(32'h0000_8000, 32'h0000_0000, 0, 0, 0, Q30));
        run_random(200);

        // extreme gains and setpoints
        drain_pipe();
        write_reg(qpat_pkg::REG_GAIN_POS, 32'h7FFF_FFFF);
        write_reg(qpat_pkg::REG_GAIN_VEL, 32'h7FFF_FFFF);
        write_reg(qpat_pkg::REG_TARGET_POS_X, 32'h8000_0000);
        write_reg(qpat_pkg::REG_TARGET_POS_Y, 32'h7FFF_FFFF);
        write_reg(qpat_pkg::REG_TARGET_POS_Z, 32'h7FFF_FFFF);
        write_reg(qpat_pkg::REG_TARGET_VEL_X, 32'h7FFF_FFFF);
        write_reg(qpat_pkg::REG_TARGET_VEL_Y, 32'h8000_0000);
        write_reg(qpat_pkg::REG_TARGET_VEL_Z, 32'h8000_0000);
        src_idle_pct = 79;
        snk_idle_pct = 14;
        send_word(make_item(32'h7FFF_FFFF, 32'h8000_0000, Q30, 0, 0, 0));
        run_random(150);

        // zero gains: u is pure gravity
        drain_pipe();
        write_reg(qpat_pkg::REG_GAIN_POS, '0);
        write_reg(qpat_pkg::REG_GAIN_VEL, '0);
        run_random(60);

        // random settings with moderate gains, no idling
        drain_pipe();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(qpat_pkg::REG_GAIN_POS, $urandom_range(32'h0008_0000));
        write_reg(qpat_pkg::REG_GAIN_VEL, $urandom_range(32'h0008_0000));
        write_reg(qpat_pkg::REG_TARGET_POS_X, $urandom);
        write_reg(qpat_pkg::REG_TARGET_POS_Y, $urandom);
        write_reg(qpat_pkg::REG_TARGET_POS_Z,
                  32'($signed($urandom_range(32'h000A_0000)) - 32'sh5_0000));
        write_reg(qpat_pkg::REG_TARGET_VEL_X, $urandom);
        write_reg(qpat_pkg::REG_TARGET_VEL_Y, 32'hFFFF_0000);
        write_reg(qpat_pkg::REG_TARGET_VEL_Z, 32'h0001_0000);
        run_random(230);

        drain_pipe();
        if (n_fail == 0)
            $display("quadrotor_position_to_attitude_thrust test passed");
        else
            $display("quadrotor_position_to_attitude_thrust test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/qpat_pkg.sv
hw/rtl/qpat_meas_if.sv
hw/rtl/qpat_cmd_if.sv
hw/rtl/qpat_core.sv
hw/rtl/quadrotor_position_to_attitude_thrust.sv
sim/qpat_checker.sv
sim/tb.sv
